@@ src/efd_pkg.sv @@
package efd_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hE0;
   localparam logic [7:0] ESC_BYTE  = 8'hD0;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_SUM  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] position;
      logic [7:0] frame_length;
      logic       checksum_ok;
      logic [7:0] computed_sum;
   } rsp_type;

endpackage

@@ src/efd_req_if.sv @@
interface efd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/efd_rsp_if.sv @@
interface efd_rsp_if;
   logic              valid;
   logic              ready;
   efd_pkg::kind_type kind;
   logic [7:0]        data_byte;
   logic [7:0]        position;
   logic [7:0]        frame_length;
   logic              checksum_ok;
   logic [7:0]        computed_sum;

   modport source (output valid, output kind, output data_byte, output position,
                   output frame_length, output checksum_ok, output computed_sum,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input position,
                   input frame_length, input checksum_ok, input computed_sum,
                   output ready);
endinterface

@@ src/efd_csr_if.sv @@
interface efd_csr_if;
   logic valid;
   logic ready;
   logic strict_checksum;

   modport source (output valid, output strict_checksum, input ready);
   modport sink   (input valid, input strict_checksum, output ready);
endinterface

@@ src/efd_frame.sv @@
module efd_frame (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic             strict,
   output logic             has_result,
   output efd_pkg::rsp_type result
);

   efd_pkg::phase_type phase_ff, phase_in;
   logic       escape_ff, escape_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] index_ff, index_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= efd_pkg::PH_HUNT;
         escape_ff    <= 1'b0;
         remaining_ff <= 8'd0;
         sum_ff       <= 8'd0;
         index_ff     <= 8'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         escape_ff    <= escape_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         index_ff     <= index_in;
      end
   end

   always_comb begin
      logic       is_data;
      logic [7:0] decoded;
      logic       ok;
      is_data      = 1'b0;
      decoded      = rx_byte;
      ok           = (rx_byte == sum_ff);
      phase_in     = phase_ff;
      escape_in    = escape_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      index_in     = index_ff;
      has_result   = 1'b0;
      result       = '0;
      case (phase_ff)
         efd_pkg::PH_HUNT: begin
            if (rx_byte == efd_pkg::SYNC_BYTE) begin
               phase_in     = efd_pkg::PH_LEN;
               escape_in    = 1'b0;
               remaining_in = 8'd0;
               sum_in       = 8'd0;
               index_in     = 8'd0;
            end
         end
         efd_pkg::PH_SUM: begin
            // checksum byte is taken raw
            has_result          = 1'b1;
            result.kind         = (!ok && strict) ? efd_pkg::KIND_ERROR : efd_pkg::KIND_END;
            result.frame_length = index_ff;
            result.checksum_ok  = ok;
            result.computed_sum = sum_ff;
            phase_in            = efd_pkg::PH_HUNT;
            escape_in           = 1'b0;
         end
         efd_pkg::PH_LEN, efd_pkg::PH_DATA: begin
            if (escape_ff) begin
               decoded   = rx_byte + 8'd1;
               escape_in = 1'b0;
               is_data   = 1'b1;
            end else if (rx_byte == efd_pkg::ESC_BYTE) begin
               escape_in = 1'b1;
            end else if (rx_byte == efd_pkg::SYNC_BYTE) begin
               // stray sync inside a frame
               has_result      = 1'b1;
               result.kind     = efd_pkg::KIND_ERROR;
               result.position = index_ff;
               phase_in        = efd_pkg::PH_HUNT;
               escape_in       = 1'b0;
            end else begin
               is_data = 1'b1;
            end
         end
         default: begin
            phase_in = efd_pkg::PH_HUNT;
         end
      endcase

      if (is_data) begin
         sum_in   = sum_ff + decoded;
         index_in = index_ff + 8'd1;
         if (phase_ff == efd_pkg::PH_LEN) begin
            // length counts itself, zero acts as one
            remaining_in = (decoded == 8'd0) ? 8'd0 : decoded - 8'd1;
         end else begin
            remaining_in = remaining_ff - 8'd1;
         end
         phase_in         = (remaining_in == 8'd0) ? efd_pkg::PH_SUM : efd_pkg::PH_DATA;
         has_result       = 1'b1;
         result.kind      = efd_pkg::KIND_DATA;
         result.data_byte = decoded;
         result.position  = index_ff;
      end
   end

   a_escape_in_frame: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (phase_ff == efd_pkg::PH_LEN || phase_ff == efd_pkg::PH_DATA))
      else $error("escape pending outside a frame");

   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (step && has_result && result.kind != efd_pkg::KIND_DATA)
      |=> phase_ff == efd_pkg::PH_HUNT)
      else $error("frame end or error did not return to hunting");

   a_data_counts: assert property (@(posedge clock) disable iff (reset)
      (step && has_result && result.kind == efd_pkg::KIND_DATA)
      |=> index_ff == $past(index_ff) + 8'd1)
      else $error("byte index did not advance on data");

endmodule

@@ src/escaped_frame_deframer.sv @@
// channel   direction  payload
// req_ch    in         rx_byte
// rsp_ch    out        kind, data_byte, position, frame_length, checksum_ok, computed_sum
// csr_ch    in         strict_checksum
//
// one byte per cycle sustained while rsp ready stays high; a byte is held in the input
// register and decoded from there into the result register, which presents its result;
// a stall on the result side can hold the byte in the input register before decoding
// reset is synchronous and leaves the block hunting for sync with strict_checksum off
// a stalled result holds its register; the input register still drains bytes that
// give no result, and req ready follows rsp ready combinationally
module escaped_frame_deframer (
   input logic      clock,
   input logic      reset,
   efd_req_if.sink  req_ch,
   efd_rsp_if.source rsp_ch,
   efd_csr_if.sink  csr_ch
);

   logic             strict_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             rsp_valid_ff;
   efd_pkg::rsp_type rsp_ff;

   logic             has_result;
   efd_pkg::rsp_type result;
   logic             out_free;
   logic             advance;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign advance       = in_valid_ff && (!has_result || out_free);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         strict_ff <= csr_ch.strict_checksum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   efd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .strict     (strict_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_ff.kind;
   assign rsp_ch.data_byte    = rsp_ff.data_byte;
   assign rsp_ch.position     = rsp_ff.position;
   assign rsp_ch.frame_length = rsp_ff.frame_length;
   assign rsp_ch.checksum_ok  = rsp_ff.checksum_ok;
   assign rsp_ch.computed_sum = rsp_ff.computed_sum;

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while result side is ready");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte was lost");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result) |=> rsp_valid_ff)
      else $error("result dropped");

endmodule
